[hdl/abd_pkg.sv]
// ----------------------------------------------------------------------------
// abd_pkg - shared definitions for the anchor box decode unit
// Field widths, fixed-point constants, stage enable type and width helpers.
// ----------------------------------------------------------------------------
package abd_pkg;

	// field widths
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 15;

	// defaults for the top level parameters
	localparam int DELTA_FRAC_BITS_DEF   = 12;
	localparam int EXP_TABLE_ENTRIES_DEF = 64;

	// fixed-point constants of the exponent path
	localparam int              EXP_Q     = 16;          // Q16 mantissa / exponent fraction
	localparam int              LOG2E_Q16 = 94548;       // log2(e) in Q16
	localparam int              LOG2E_W   = 18;          // signed width that holds it
	localparam longint unsigned LN2_Q30   = 744261118;   // ln(2) in Q30
	localparam int              TAB_W     = 18;          // 2^x table entries, Q16, up to 2.0
	localparam int              DIFF_W    = 14;          // neighbouring entry differences

	// clamp limits of the corner outputs
	localparam int COORD_MAX = 32767;
	localparam int COORD_MIN = -32768;

	// pipeline depth, output register included
	localparam int NUM_STAGES = 9;

	typedef logic [NUM_STAGES:1] stage_en_t;

	// width of the predicted centre: anchor centre plus rounded delta term
	function automatic int pc_width(int delta_frac_bits);
		int rc_w;
		rc_w = COORD_W + SIZE_W + 2 - delta_frac_bits;
		return ((rc_w > COORD_W) ? rc_w : COORD_W) + 1;
	endfunction

endpackage

[hdl/anchor_box_decode_unit.sv]
// ----------------------------------------------------------------------------
// anchor_box_decode_unit - anchor box delta decode, centre form to corners
// Streams one anchor with its four deltas in and one saturated corner box out.
// ----------------------------------------------------------------------------
// Each input transaction carries an anchor (centre x/y in signed Q12.4, width
// and height in unsigned Q11.4) and four deltas in signed Q4.12. The unit
// forms the predicted centre as anchor centre + delta * anchor size, the
// predicted size as anchor size * exp(log scale), and returns the corners
// centre -/+ half size, clamped to 16 bits with a flag raised when any corner
// was clamped. exp is done as a power of two: the integer part is a shift and
// the fraction comes from a linearly interpolated table of 2^(i/N) that is
// built at elaboration. A new transaction may enter on every clock unless the
// corner side stalls; there are 9 register stages (products, rounding, table
// position, table read, interpolation, mantissa, size product, scaling
// shift, corner clamp). Each stage holds its own valid bit, so a stall on the
// corner side holds only the occupied stages and bubbles still close up.
// ----------------------------------------------------------------------------
module anchor_box_decode_unit import abd_pkg::*; #(
	parameter int DELTA_FRAC_BITS   = DELTA_FRAC_BITS_DEF,
	parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// anchor channel
	input  logic                      anchor_valid,
	output logic                      anchor_stall,
	input  logic signed [COORD_W-1:0] prior_cx,
	input  logic signed [COORD_W-1:0] prior_cy,
	input  logic        [SIZE_W-1:0]  prior_w,
	input  logic        [SIZE_W-1:0]  prior_h,
	input  logic signed [COORD_W-1:0] delta_x,
	input  logic signed [COORD_W-1:0] delta_y,
	input  logic signed [COORD_W-1:0] log_scale_w,
	input  logic signed [COORD_W-1:0] log_scale_h,
	// corner channel
	output logic                      corner_valid,
	input  logic                      corner_stall,
	output logic signed [COORD_W-1:0] corner_x1,
	output logic signed [COORD_W-1:0] corner_y1,
	output logic signed [COORD_W-1:0] corner_x2,
	output logic signed [COORD_W-1:0] corner_y2,
	output logic                      saturated
);

	localparam int PC_W = pc_width(DELTA_FRAC_BITS);
	localparam int HS_W = PC_W + 1;
	localparam int CW   = PC_W + 2;   // centre +/- half size, before clamping

	// Stage control. A stage loads when it is empty or the one after it
	// loads; the output stage loads when empty or when the sink takes it.
	stage_en_t en;
	stage_en_t vld_q;

	always_comb begin
		en[NUM_STAGES] = !vld_q[NUM_STAGES] || !corner_stall;
		for (int n = NUM_STAGES - 1; n >= 1; n--)
			en[n] = !vld_q[n] || en[n+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= anchor_valid;
			for (int n = 2; n <= NUM_STAGES; n++) begin
				if (en[n])
					vld_q[n] <= vld_q[n-1];
			end
		end
	end

	assign anchor_stall = !en[1];
	assign corner_valid = vld_q[NUM_STAGES];

	// Both axes run the same eight-stage path side by side.
	logic signed [PC_W-1:0] pc_x;
	logic signed [PC_W-1:0] pc_y;
	logic        [HS_W-1:0] hs_x;
	logic        [HS_W-1:0] hs_y;

	abd_axis #(
		.DELTA_FRAC_BITS  (DELTA_FRAC_BITS),
		.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
	) u_axis_x (
		.clk      (clk),
		.en       (en),
		.anchor_c (prior_cx),
		.size     (prior_w),
		.delta    (delta_x),
		.log_scale(log_scale_w),
		.pc       (pc_x),
		.hs       (hs_x)
	);

	abd_axis #(
		.DELTA_FRAC_BITS  (DELTA_FRAC_BITS),
		.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
	) u_axis_y (
		.clk      (clk),
		.en       (en),
		.anchor_c (prior_cy),
		.size     (prior_h),
		.delta    (delta_y),
		.log_scale(log_scale_h),
		.pc       (pc_y),
		.hs       (hs_y)
	);

	// Corner stage. The half size arrives already capped at a value past any
	// reachable centre, so a capped half size clamps both corners just as
	// the unbounded value would. Order: x1, y1, x2, y2.
	logic signed [CW-1:0]      corner_wide [4];
	logic signed [COORD_W-1:0] corner_sat  [4];
	logic        [3:0]         clip;

	assign corner_wide[0] = CW'(pc_x) - $signed(CW'(hs_x));
	assign corner_wide[1] = CW'(pc_y) - $signed(CW'(hs_y));
	assign corner_wide[2] = CW'(pc_x) + $signed(CW'(hs_x));
	assign corner_wide[3] = CW'(pc_y) + $signed(CW'(hs_y));

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (corner_wide[i] > CW'(COORD_MAX)) begin
				corner_sat[i] = COORD_W'(COORD_MAX);
				clip[i]       = 1'b1;
			end else if (corner_wide[i] < CW'(COORD_MIN)) begin
				corner_sat[i] = COORD_W'(COORD_MIN);
				clip[i]       = 1'b1;
			end else begin
				corner_sat[i] = COORD_W'(corner_wide[i]);
				clip[i]       = 1'b0;
			end
		end
	end

	// Output register: holds while the sink stalls.
	logic signed [COORD_W-1:0] corner_s9 [4];
	logic                      sat_s9;

	always_ff @(posedge clk) begin
		if (en[NUM_STAGES]) begin
			for (int i = 0; i < 4; i++)
				corner_s9[i] <= corner_sat[i];
			sat_s9 <= |clip;
		end
	end

	assign corner_x1 = corner_s9[0];
	assign corner_y1 = corner_s9[1];
	assign corner_x2 = corner_s9[2];
	assign corner_y2 = corner_s9[3];
	assign saturated = sat_s9;

endmodule

[hdl/abd_axis.sv]
// ----------------------------------------------------------------------------
// abd_axis - one axis of the anchor box decode
// Eight register stages giving the predicted centre and the half size
// round(size * 2^(log_scale * log2(e)) / 2), the latter capped where the
// corners would saturate anyway.
// ----------------------------------------------------------------------------
module abd_axis import abd_pkg::*; #(
	parameter int DELTA_FRAC_BITS   = DELTA_FRAC_BITS_DEF,
	parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF,
	localparam int PC_W = pc_width(DELTA_FRAC_BITS),
	localparam int HS_W = PC_W + 1
) (
	input  logic                      clk,
	input  stage_en_t                 en,
	input  logic signed [COORD_W-1:0] anchor_c,
	input  logic        [SIZE_W-1:0]  size,
	input  logic signed [COORD_W-1:0] delta,
	input  logic signed [COORD_W-1:0] log_scale,
	output logic signed [PC_W-1:0]    pc,
	output logic        [HS_W-1:0]    hs
);

	localparam int CP_W = COORD_W + SIZE_W + 1;          // delta * size
	localparam int RC_W = CP_W + 1 - DELTA_FRAC_BITS;    // rounded centre offset
	localparam int YP_W = COORD_W + LOG2E_W;             // log_scale * log2(e)
	localparam int Y_W  = YP_W + 1 - DELTA_FRAC_BITS;    // exponent, Q16
	localparam int K_W  = Y_W - EXP_Q;                   // integer part of exponent
	localparam int E_W  = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam int J_W  = EXP_Q + E_W;
	localparam int IW   = $clog2(EXP_TABLE_ENTRIES);
	localparam int DM_W = DIFF_W + EXP_Q;
	localparam int M_W  = TAB_W;
	localparam int P_W  = SIZE_W + M_W;
	localparam int SW   = K_W + 7;
	localparam int RA_W = $clog2(P_W + 1);
	localparam int LA_W = $clog2(PC_W + 1);
	localparam int WV_W = P_W + PC_W;

	localparam longint unsigned E_HALF = EXP_TABLE_ENTRIES / 2;

	typedef logic [EXP_TABLE_ENTRIES-1:0][TAB_W-1:0]  lo_tab_t;
	typedef logic [EXP_TABLE_ENTRIES-1:0][DIFF_W-1:0] dt_tab_t;

	// shift and subtract long division, only used while building the tables
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 2^(i/E) in Q16 via the truncating Q30 Taylor series of e^(i*ln2/E)
	function automatic longint unsigned exp_q16(int unsigned i);
		longint unsigned ii;
		longint unsigned z;
		longint unsigned sum;
		longint unsigned term;
		ii   = i;
		z    = udiv(ii * LN2_Q30 + E_HALF, EXP_TABLE_ENTRIES);
		sum  = 64'd1 << 30;
		term = 64'd1 << 30;
		for (int unsigned n = 1; n <= 24; n++) begin
			if (term != 0) begin
				term = udiv((term * z) >> 30, n);
				sum  = sum + term;
			end
		end
		return (sum + (64'd1 << 13)) >> 14;
	endfunction

	function automatic lo_tab_t build_lo();
		lo_tab_t t;
		for (int i = 0; i < EXP_TABLE_ENTRIES; i++)
			t[i] = TAB_W'(exp_q16(i));
		return t;
	endfunction

	function automatic dt_tab_t build_dt();
		dt_tab_t t;
		for (int i = 0; i < EXP_TABLE_ENTRIES; i++)
			t[i] = DIFF_W'(exp_q16(i + 1) - exp_q16(i));
		return t;
	endfunction

	localparam lo_tab_t EXP_LO = build_lo();
	localparam dt_tab_t EXP_DT = build_dt();

	// stage 1: products
	logic signed [CP_W-1:0]    cprod_s1;
	logic signed [YP_W-1:0]    tprod_s1;
	logic signed [COORD_W-1:0] ac_s1;
	logic        [SIZE_W-1:0]  size_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cprod_s1 <= delta * $signed({1'b0, size});
			tprod_s1 <= log_scale * $signed(LOG2E_W'(LOG2E_Q16));
			ac_s1    <= anchor_c;
			size_s1  <= size;
		end
	end

	// stage 2: centre and exponent, both rounded half up
	logic signed [CP_W:0]   csum;
	logic signed [RC_W-1:0] crnd;
	logic signed [YP_W:0]   ysum;
	logic signed [Y_W-1:0]  yval;

	assign csum = {cprod_s1[CP_W-1], cprod_s1} + (CP_W+1)'(2 ** (DELTA_FRAC_BITS - 1));
	assign crnd = RC_W'(csum >>> DELTA_FRAC_BITS);
	assign ysum = {tprod_s1[YP_W-1], tprod_s1} + (YP_W+1)'(2 ** (DELTA_FRAC_BITS - 1));
	assign yval = Y_W'(ysum >>> DELTA_FRAC_BITS);

	logic signed [PC_W-1:0]  pc_s2;
	logic signed [K_W-1:0]   k_s2;
	logic        [EXP_Q-1:0] f_s2;
	logic        [SIZE_W-1:0] size_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pc_s2   <= PC_W'(ac_s1) + PC_W'(crnd);
			k_s2    <= yval[Y_W-1:EXP_Q];
			f_s2    <= yval[EXP_Q-1:0];
			size_s2 <= size_s1;
		end
	end

	// stage 3: table position
	logic [J_W-1:0] jpos;

	assign jpos = f_s2 * E_W'(EXP_TABLE_ENTRIES);

	logic        [IW-1:0]     idx_s3;
	logic        [EXP_Q-1:0]  r_s3;
	logic signed [PC_W-1:0]   pc_s3;
	logic signed [K_W-1:0]    k_s3;
	logic        [SIZE_W-1:0] size_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			idx_s3  <= jpos[EXP_Q +: IW];
			r_s3    <= jpos[EXP_Q-1:0];
			pc_s3   <= pc_s2;
			k_s3    <= k_s2;
			size_s3 <= size_s2;
		end
	end

	// stage 4: table read
	logic        [TAB_W-1:0]  lo_s4;
	logic        [DIFF_W-1:0] dlt_s4;
	logic        [EXP_Q-1:0]  r_s4;
	logic signed [PC_W-1:0]   pc_s4;
	logic signed [K_W-1:0]    k_s4;
	logic        [SIZE_W-1:0] size_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			lo_s4   <= EXP_LO[idx_s3];
			dlt_s4  <= EXP_DT[idx_s3];
			r_s4    <= r_s3;
			pc_s4   <= pc_s3;
			k_s4    <= k_s3;
			size_s4 <= size_s3;
		end
	end

	// stage 5: interpolation product
	logic        [DM_W-1:0]   dm_s5;
	logic        [TAB_W-1:0]  lo_s5;
	logic signed [PC_W-1:0]   pc_s5;
	logic signed [K_W-1:0]    k_s5;
	logic        [SIZE_W-1:0] size_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			dm_s5   <= dlt_s4 * r_s4;
			lo_s5   <= lo_s4;
			pc_s5   <= pc_s4;
			k_s5    <= k_s4;
			size_s5 <= size_s4;
		end
	end

	// stage 6: mantissa
	logic [DM_W:0] dsum;

	assign dsum = {1'b0, dm_s5} + (DM_W+1)'(2 ** (EXP_Q - 1));

	logic        [M_W-1:0]    m_s6;
	logic signed [PC_W-1:0]   pc_s6;
	logic signed [K_W-1:0]    k_s6;
	logic        [SIZE_W-1:0] size_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			m_s6    <= lo_s5 + M_W'(dsum >> EXP_Q);
			pc_s6   <= pc_s5;
			k_s6    <= k_s5;
			size_s6 <= size_s5;
		end
	end

	// stage 7: size times mantissa
	logic        [P_W-1:0]  p_s7;
	logic signed [PC_W-1:0] pc_s7;
	logic signed [K_W-1:0]  k_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			p_s7  <= size_s6 * m_s6;
			pc_s7 <= pc_s6;
			k_s7  <= k_s6;
		end
	end

	// stage 8: scale by 2^(k-17), round half up, cap
	logic signed [SW-1:0]   sft;
	logic        [RA_W-1:0] rsm1;
	logic        [LA_W-1:0] lsa;
	logic        [P_W-1:0]  qsh;
	logic        [P_W:0]    qinc;
	logic        [WV_W-1:0] wval;

	assign sft = SW'(EXP_Q + 1) - SW'(k_s7);

	always_comb begin
		rsm1 = '0;
		lsa  = '0;
		qsh  = '0;
		qinc = '0;
		if (sft > 0) begin
			// a shift past the product width rounds to zero
			if (sft > SW'(P_W + 1))
				rsm1 = RA_W'(P_W);
			else
				rsm1 = RA_W'(sft - SW'(1));
			qsh  = p_s7 >> rsm1;
			qinc = {1'b0, qsh} + (P_W+1)'(1);
			wval = WV_W'(qinc[P_W:1]);
		end else begin
			// any non-zero product shifted this far is past the cap
			if (-sft > SW'(PC_W))
				lsa = LA_W'(PC_W);
			else
				lsa = LA_W'(-sft);
			wval = WV_W'(p_s7) << lsa;
		end
	end

	logic signed [PC_W-1:0] pc_s8;
	logic        [HS_W-1:0] hs_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			pc_s8 <= pc_s7;
			if (wval >= (WV_W'(1) << PC_W))
				hs_s8 <= HS_W'(1) << PC_W;
			else
				hs_s8 <= HS_W'(wval);
		end
	end

	assign pc = pc_s8;
	assign hs = hs_s8;

endmodule

[bench/anchor_box_decode_checker.sv]
// ----------------------------------------------------------------------------
// anchor_box_decode_checker - corner box predictor and scoreboard
// Watches both channels of the anchor box decode unit. Every accepted anchor
// transaction gets its corner box predicted in fixed point. Every accepted
// corner transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module anchor_box_decode_checker import abd_pkg::*; #(
	parameter int DELTA_FRAC_BITS   = DELTA_FRAC_BITS_DEF,
	parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      anchor_valid,
	input  logic                      anchor_stall,
	input  logic signed [COORD_W-1:0] prior_cx,
	input  logic signed [COORD_W-1:0] prior_cy,
	input  logic        [SIZE_W-1:0]  prior_w,
	input  logic        [SIZE_W-1:0]  prior_h,
	input  logic signed [COORD_W-1:0] delta_x,
	input  logic signed [COORD_W-1:0] delta_y,
	input  logic signed [COORD_W-1:0] log_scale_w,
	input  logic signed [COORD_W-1:0] log_scale_h,
	input  logic                      corner_valid,
	input  logic                      corner_stall,
	input  logic signed [COORD_W-1:0] corner_x1,
	input  logic signed [COORD_W-1:0] corner_y1,
	input  logic signed [COORD_W-1:0] corner_x2,
	input  logic signed [COORD_W-1:0] corner_y2,
	input  logic                      saturated,
	output int                        failures,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
		logic                      sat;
	} corner_box_t;

	// 2^(i/N) in Q16, i = 0..N
	longint      pow2_frac [0:EXP_TABLE_ENTRIES];
	corner_box_t expected_boxes [$];
	int          error_count = 0;

	initial begin
		longint unsigned z, sum, term;
		for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
			z    = (longint'(i) * LN2_Q30 + EXP_TABLE_ENTRIES / 2) / EXP_TABLE_ENTRIES;
			sum  = 64'd1 << 30;
			term = 64'd1 << 30;
			for (int n = 1; n <= 24 && term != 0; n++) begin
				term = ((term * z) >> 30) / n;
				sum += term;
			end
			pow2_frac[i] = longint'((sum + (64'd1 << 13)) >> 14);
		end
	end

	// half-up rounding right shift
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// size * exp(t) / 2, t in Q(DELTA_FRAC_BITS)
	function automatic longint half_extent(longint size, longint t);
		longint y, k, f, j, idx, r, m, p, s;
		y   = round_shift(t * LOG2E_Q16, DELTA_FRAC_BITS);
		k   = y >>> EXP_Q;
		f   = y & 64'hFFFF;
		j   = f * EXP_TABLE_ENTRIES;
		idx = j >> EXP_Q;
		r   = j & 64'hFFFF;
		if (idx >= EXP_TABLE_ENTRIES)
			idx = EXP_TABLE_ENTRIES - 1;
		m = pow2_frac[idx] + round_shift((pow2_frac[idx+1] - pow2_frac[idx]) * r, EXP_Q);
		p = size * m;
		if (p == 0)
			return 0;
		s = 17 - k;
		if (s <= 0) begin
			// huge scale: cap stands in for the unbounded value
			if (-s >= 24)
				return longint'(1) << 56;
			return p << (-s);
		end
		if (s >= 40)
			return 0;
		return (p + (longint'(1) << (s - 1))) >> s;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(longint v, inout logic sat);
		if (v > COORD_MAX) begin
			sat = 1'b1;
			return COORD_W'(COORD_MAX);
		end
		if (v < COORD_MIN) begin
			sat = 1'b1;
			return COORD_W'(COORD_MIN);
		end
		return COORD_W'(v);
	endfunction

	function automatic corner_box_t decode_box();
		corner_box_t box;
		longint      pcx, pcy, hw, hh;
		pcx = longint'(prior_cx)
			+ round_shift(longint'(delta_x) * longint'(prior_w), DELTA_FRAC_BITS);
		pcy = longint'(prior_cy)
			+ round_shift(longint'(delta_y) * longint'(prior_h), DELTA_FRAC_BITS);
		hw = half_extent(longint'(prior_w), longint'(log_scale_w));
		hh = half_extent(longint'(prior_h), longint'(log_scale_h));
		box.sat = 1'b0;
		box.x1  = clamp_coord(pcx - hw, box.sat);
		box.y1  = clamp_coord(pcy - hh, box.sat);
		box.x2  = clamp_coord(pcx + hw, box.sat);
		box.y2  = clamp_coord(pcy + hh, box.sat);
		return box;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		corner_box_t want;
		if (arst_n) begin
			if (corner_valid && !corner_stall) begin
				if (expected_boxes.size() == 0) begin
					$display("%0t: corner transaction with none expected, actual %0d %0d %0d %0d %0b",
						$time, corner_x1, corner_y1, corner_x2, corner_y2, saturated);
					error_count++;
				end else begin
					want = expected_boxes.pop_front();
					check_field("corner_x1", want.x1, corner_x1);
					check_field("corner_y1", want.y1, corner_y1);
					check_field("corner_x2", want.x2, corner_x2);
					check_field("corner_y2", want.y2, corner_y2);
					check_field("saturated", want.sat, saturated);
				end
			end
			if (anchor_valid && !anchor_stall)
				expected_boxes.push_back(decode_box());
		end
		failures    <= error_count;
		outstanding <= expected_boxes.size();
	end

endmodule

[bench/anchor_box_decode_unit_test.sv]
// ----------------------------------------------------------------------------
// anchor_box_decode_unit_test - stream test of the anchor box decode unit
// Drives directed corner cases then random anchors under three idle/stall
// mixes; a separate checker predicts every corner box and compares.
// ----------------------------------------------------------------------------
module anchor_box_decode_unit_test;
	import abd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_PER_PHASE = 580;
	// ~1800 transactions under stall, with room many times over
	localparam int CYCLE_LIMIT     = 400000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      anchor_valid = 1'b0;
	logic                      anchor_stall;
	logic signed [COORD_W-1:0] prior_cx = '0;
	logic signed [COORD_W-1:0] prior_cy = '0;
	logic        [SIZE_W-1:0]  prior_w = '0;
	logic        [SIZE_W-1:0]  prior_h = '0;
	logic signed [COORD_W-1:0] delta_x = '0;
	logic signed [COORD_W-1:0] delta_y = '0;
	logic signed [COORD_W-1:0] log_scale_w = '0;
	logic signed [COORD_W-1:0] log_scale_h = '0;
	logic                      corner_valid;
	logic                      corner_stall = 1'b0;
	logic signed [COORD_W-1:0] corner_x1, corner_y1, corner_x2, corner_y2;
	logic                      saturated;

	int failures;
	int outstanding;
	int cycle_count = 0;
	// percentages of cycles in which the sender idles / the receiver stalls
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always #5 clk = ~clk;

	anchor_box_decode_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.anchor_valid(anchor_valid),
		.anchor_stall(anchor_stall),
		.prior_cx    (prior_cx),
		.prior_cy    (prior_cy),
		.prior_w     (prior_w),
		.prior_h     (prior_h),
		.delta_x     (delta_x),
		.delta_y     (delta_y),
		.log_scale_w (log_scale_w),
		.log_scale_h (log_scale_h),
		.corner_valid(corner_valid),
		.corner_stall(corner_stall),
		.corner_x1   (corner_x1),
		.corner_y1   (corner_y1),
		.corner_x2   (corner_x2),
		.corner_y2   (corner_y2),
		.saturated   (saturated)
	);

	anchor_box_decode_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.anchor_valid(anchor_valid),
		.anchor_stall(anchor_stall),
		.prior_cx    (prior_cx),
		.prior_cy    (prior_cy),
		.prior_w     (prior_w),
		.prior_h     (prior_h),
		.delta_x     (delta_x),
		.delta_y     (delta_y),
		.log_scale_w (log_scale_w),
		.log_scale_h (log_scale_h),
		.corner_valid(corner_valid),
		.corner_stall(corner_stall),
		.corner_x1   (corner_x1),
		.corner_y1   (corner_y1),
		.corner_x2   (corner_x2),
		.corner_y2   (corner_y2),
		.saturated   (saturated),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Receiver back-pressure: a fresh draw every clock, so stalls land on
	// every pipeline phase. Zero percent gives a stretch with no stalls.
	always @(posedge clk) begin
		corner_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: any hang (lost or never-delivered corner box) ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("anchor_box_decode_unit_test failed");
			$finish;
		end
	end

	// One anchor transaction. Random idle cycles go in front of it, then the
	// payload is held until the unit takes it. valid stays high into the next
	// call when no idle is drawn, so back-to-back transactions get through.
	task automatic send_anchor(
		input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
		input logic        [SIZE_W-1:0]  w,  input logic        [SIZE_W-1:0]  h,
		input logic signed [COORD_W-1:0] dx, input logic signed [COORD_W-1:0] dy,
		input logic signed [COORD_W-1:0] tw, input logic signed [COORD_W-1:0] th
	);
		while ($urandom_range(99) < send_idle_pct) begin
			anchor_valid <= 1'b0;
			@(posedge clk);
		end
		anchor_valid <= 1'b1;
		prior_cx     <= cx;
		prior_cy     <= cy;
		prior_w      <= w;
		prior_h      <= h;
		delta_x      <= dx;
		delta_y      <= dy;
		log_scale_w  <= tw;
		log_scale_h  <= th;
		@(posedge clk);
		while (anchor_stall)
			@(posedge clk);
	endtask

	// Hold the sender off until every predicted box has come back. The extra
	// edge lets the checker's count catch up with the last accepted anchor.
	task automatic drain_corners();
		anchor_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [COORD_W-1:0] cx, cy, dx, dy, tw, th;
		logic        [SIZE_W-1:0]  w, h;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 10;
		recv_stall_pct = 55;

		// --- directed: field extremes and the named special cases ---
		// all zero: zero size, zero deltas
		send_anchor(16'sd0, 16'sd0, 15'd0, 15'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		// plain box, unit scale (exp(0) = 1)
		send_anchor(16'sd160, -16'sd160, 15'd64, 15'd32, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		// coordinate extremes with nothing else, corners sit on the limits
		send_anchor(16'sh7FFF, 16'sh8000, 15'd0, 15'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		// largest anchor size, largest log scale: every corner clamps
		send_anchor(16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		// most negative everything: lower clamp
		send_anchor(16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		// tiny scale: half size shrinks far below the anchor size, box hugs the centre
		send_anchor(16'sd100, 16'sd200, 15'h7FFF, 15'h7FFF,
			16'sd0, 16'sd0, 16'sh8000, 16'sh8000);
		// huge scale on a zero-size anchor still gives zero half size
		send_anchor(-16'sd50, 16'sd50, 15'd0, 15'd0,
			16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
		// huge scale on the smallest non-zero size
		send_anchor(16'sd0, 16'sd0, 15'd1, 15'd1, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF);
		// scale exactly ln(2)-ish and -ln(2)-ish, table ends and interpolation
		send_anchor(16'sd0, 16'sd0, 15'd256, 15'd256, 16'sd0, 16'sd0, 16'sd2839, -16'sd2839);
		send_anchor(16'sd0, 16'sd0, 15'd256, 15'd256, 16'sd0, 16'sd0, 16'sd1, -16'sd1);
		// half-up rounding of the centre term: +0.5 and -0.5 of a size step
		send_anchor(16'sd0, 16'sd0, 15'd1, 15'd1, 16'sd2048, -16'sd2048, 16'sd0, 16'sd0);
		// centre pushed out of range by the delta alone, small box
		send_anchor(16'sh7F00, 16'sh8100, 15'h7FFF, 15'h7FFF,
			16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
		// one corner clamps, the other does not
		send_anchor(16'sh7FF0, 16'sd0, 15'd64, 15'd64, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		// alternating bit patterns
		send_anchor(16'sh5555, 16'shAAAA, 15'h2AAA, 15'h5555,
			16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
		send_anchor(16'shAAAA, 16'sh5555, 15'h5555, 15'h2AAA,
			16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);

		// --- random: three idle/stall mixes, drained in between ---
		for (int phase = 0; phase < 3; phase++) begin
			drain_corners();
			case (phase)
				0: begin
					send_idle_pct  = 10;
					recv_stall_pct = 55;
				end
				1: begin
					send_idle_pct  = 55;
					recv_stall_pct = 10;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(1)) begin
					// full-range fields: every bit toggles, mostly saturating
					cx = COORD_W'($urandom_range(65535));
					cy = COORD_W'($urandom_range(65535));
					w  = SIZE_W'($urandom_range(32767));
					h  = SIZE_W'($urandom_range(32767));
					dx = COORD_W'($urandom_range(65535));
					dy = COORD_W'($urandom_range(65535));
					tw = COORD_W'($urandom_range(65535));
					th = COORD_W'($urandom_range(65535));
				end else begin
					// plausible detections: boxes that mostly stay in range
					cx = COORD_W'(int'($urandom_range(16383)) - 8192);
					cy = COORD_W'(int'($urandom_range(16383)) - 8192);
					w  = ($urandom_range(7) == 0) ? '0 : SIZE_W'($urandom_range(2047));
					h  = ($urandom_range(7) == 0) ? '0 : SIZE_W'($urandom_range(2047));
					dx = COORD_W'(int'($urandom_range(4095)) - 2048);
					dy = COORD_W'(int'($urandom_range(4095)) - 2048);
					tw = COORD_W'(int'($urandom_range(8191)) - 4096);
					th = COORD_W'(int'($urandom_range(8191)) - 4096);
				end
				send_anchor(cx, cy, w, h, dx, dy, tw, th);
			end
		end

		drain_corners();
		// grace period for stray transactions
		repeat (2 * NUM_STAGES) @(posedge clk);
		if (failures == 0)
			$display("anchor_box_decode_unit_test passed");
		else
			$display("anchor_box_decode_unit_test failed");
		$finish;
	end

endmodule

[anchor_box_decode_unit.f]
hdl/abd_pkg.sv
hdl/abd_axis.sv
hdl/anchor_box_decode_unit.sv
bench/anchor_box_decode_checker.sv
bench/anchor_box_decode_unit_test.sv
